[design/hrl_pkg.sv]
// ----------------------------------------------------------------------------
// hrl_pkg
// shared codes and helpers for the hex record loader
// ----------------------------------------------------------------------------
package hrl_pkg;

    // parser phases
    localparam logic [2:0] PH_LINE_START = 3'd0;
    localparam logic [2:0] PH_COUNT      = 3'd1;
    localparam logic [2:0] PH_ADDRESS    = 3'd2;
    localparam logic [2:0] PH_TYPE       = 3'd3;
    localparam logic [2:0] PH_DATA       = 3'd4;
    localparam logic [2:0] PH_CHECKSUM   = 3'd5;
    localparam logic [2:0] PH_SKIP       = 3'd6;

    // result kinds
    localparam logic [1:0] KIND_WRITE    = 2'd0;
    localparam logic [1:0] KIND_OK       = 2'd1;
    localparam logic [1:0] KIND_CHECKSUM = 2'd2;
    localparam logic [1:0] KIND_FORMAT   = 2'd3;

    // characters
    localparam logic [7:0] CHAR_COLON    = 8'h3a;
    localparam logic [7:0] CHAR_NEWLINE  = 8'h0a;

    // bit 4 set marks a non-hex character, bits 3:0 hold the nibble
    typedef logic [4:0] nibble_t;

    function automatic nibble_t hex_nibble(input logic [7:0] ch);
        nibble_t res;
        res = 5'h10;
        case (ch) inside
            [8'h30:8'h39]: res = {1'b0, ch[3:0]};
            [8'h41:8'h46],
            [8'h61:8'h66]: res = {1'b0, ch[3:0] + 4'd9};
            default:       res = 5'h10;
        endcase
        return res;
    endfunction

endpackage

[design/hex_record_loader.sv]
// ----------------------------------------------------------------------------
// hex_record_loader
// decodes hex-record text into byte writes and per-record status
// ----------------------------------------------------------------------------
// One ASCII character is taken per request on the slave side, one per clock
// cycle when the master side keeps up. Each character updates the parser and
// may load one result into the output register, which is
// refilled in the same cycle it drains, so s_tready only drops while a result
// waits and m_tready is low. Results: a data write for every data byte (address
// is record base plus offset, wrapping at 16 bits), then record ok or checksum
// error after the checksum byte. A line not opening with a colon, or a non-hex
// character inside a record, gives a format error. After a checksum or format
// error the block keeps accepting characters but ignores them until reset.
// Text after a good record is skipped up to and including the newline.
// ----------------------------------------------------------------------------
module hex_record_loader
    import hrl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] character
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] address, [23:16] data_byte, [31:24] record_type
    output logic [1:0]  m_tuser    // [1:0] kind
);

    // parser state
    logic [2:0]  phase_reg,     phase_next;
    logic [1:0]  digit_pos_reg, digit_pos_next;
    logic [7:0]  byte_count_reg, byte_count_next;
    logic [7:0]  bytes_left_reg, bytes_left_next;
    logic [15:0] base_addr_reg, base_addr_next;
    logic [7:0]  offset_reg,    offset_next;
    logic [7:0]  type_reg,      type_next;
    logic [7:0]  sum_reg,       sum_next;
    logic [3:0]  high_nib_reg,  high_nib_next;
    logic        halted_reg,    halted_next;

    // result register
    logic        m_valid_reg,   m_valid_next;
    logic [1:0]  kind_reg;
    logic [15:0] addr_reg;
    logic [7:0]  data_reg;
    logic [7:0]  rtype_reg;

    logic        in_fire;
    logic        out_load;
    logic [1:0]  out_kind;
    logic [15:0] out_addr;
    logic [7:0]  out_data;
    logic [7:0]  out_type;
    nibble_t     nib;
    logic [7:0]  byte_val;
    logic [7:0]  sum_add;

    // output register frees up when empty or being taken this cycle
    assign s_tready = !m_valid_reg || m_tready;
    assign in_fire  = s_tvalid && s_tready;

    assign nib      = hex_nibble(s_tdata);
    assign byte_val = {high_nib_reg, nib[3:0]};
    assign sum_add  = sum_reg + byte_val;

    always_comb begin
        phase_next      = phase_reg;
        digit_pos_next  = digit_pos_reg;
        byte_count_next = byte_count_reg;
        bytes_left_next = bytes_left_reg;
        base_addr_next  = base_addr_reg;
        offset_next     = offset_reg;
        type_next       = type_reg;
        sum_next        = sum_reg;
        high_nib_next   = high_nib_reg;
        halted_next     = halted_reg;
        out_load        = 1'b0;
        out_kind        = KIND_WRITE;
        out_addr        = '0;
        out_data        = '0;
        out_type        = '0;

        if (in_fire && !halted_reg) begin
            case (phase_reg)
                PH_SKIP: begin
                    if (s_tdata == CHAR_NEWLINE) begin
                        phase_next = PH_LINE_START;
                    end
                end
                PH_LINE_START: begin
                    if (s_tdata != CHAR_COLON) begin
                        halted_next = 1'b1;
                        out_load    = 1'b1;
                        out_kind    = KIND_FORMAT;
                    end else begin
                        phase_next     = PH_COUNT;
                        digit_pos_next = '0;
                        sum_next       = '0;
                        offset_next    = '0;
                    end
                end
                PH_COUNT, PH_ADDRESS, PH_TYPE, PH_DATA, PH_CHECKSUM: begin
                    if (nib[4]) begin
                        // non-hex character inside a record
                        halted_next = 1'b1;
                        out_load    = 1'b1;
                        out_kind    = KIND_FORMAT;
                    end else begin
                        if (phase_reg == PH_ADDRESS) begin
                            base_addr_next = {base_addr_reg[11:0], nib[3:0]};
                        end
                        if (!digit_pos_reg[0]) begin
                            // first digit of a byte
                            high_nib_next  = nib[3:0];
                            digit_pos_next = digit_pos_reg + 2'd1;
                        end else begin
                            sum_next = sum_add;
                            case (phase_reg)
                                PH_COUNT: begin
                                    byte_count_next = byte_val;
                                    phase_next      = PH_ADDRESS;
                                    digit_pos_next  = '0;
                                end
                                PH_ADDRESS: begin
                                    if (digit_pos_reg != 2'd3) begin
                                        digit_pos_next = digit_pos_reg + 2'd1;
                                    end else begin
                                        phase_next     = PH_TYPE;
                                        digit_pos_next = '0;
                                    end
                                end
                                PH_TYPE: begin
                                    type_next       = byte_val;
                                    bytes_left_next = byte_count_reg;
                                    // zero count goes straight to the checksum
                                    phase_next      = (byte_count_reg == 8'd0) ?
                                                      PH_CHECKSUM : PH_DATA;
                                    digit_pos_next  = '0;
                                end
                                PH_DATA: begin
                                    offset_next     = offset_reg + 8'd1;
                                    bytes_left_next = bytes_left_reg - 8'd1;
                                    if (bytes_left_reg == 8'd1) begin
                                        phase_next = PH_CHECKSUM;
                                    end
                                    digit_pos_next  = '0;
                                    out_load        = 1'b1;
                                    out_kind        = KIND_WRITE;
                                    out_addr        = base_addr_reg + {8'd0, offset_reg};
                                    out_data        = byte_val;
                                    out_type        = type_reg;
                                end
                                default: begin
                                    // checksum byte closes the record
                                    digit_pos_next = '0;
                                    out_load       = 1'b1;
                                    out_type       = type_reg;
                                    if (sum_add != 8'd0) begin
                                        halted_next = 1'b1;
                                        out_kind    = KIND_CHECKSUM;
                                    end else begin
                                        phase_next = PH_SKIP;
                                        out_kind   = KIND_OK;
                                    end
                                end
                            endcase
                        end
                    end
                end
                default: begin
                    halted_next = 1'b1;
                    out_load    = 1'b1;
                    out_kind    = KIND_FORMAT;
                end
            endcase
        end
    end

    always_comb begin
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_LINE_START;
            digit_pos_reg  <= '0;
            byte_count_reg <= '0;
            bytes_left_reg <= '0;
            base_addr_reg  <= '0;
            offset_reg     <= '0;
            type_reg       <= '0;
            sum_reg        <= '0;
            high_nib_reg   <= '0;
            halted_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            phase_reg      <= phase_next;
            digit_pos_reg  <= digit_pos_next;
            byte_count_reg <= byte_count_next;
            bytes_left_reg <= bytes_left_next;
            base_addr_reg  <= base_addr_next;
            offset_reg     <= offset_next;
            type_reg       <= type_next;
            sum_reg        <= sum_next;
            high_nib_reg   <= high_nib_next;
            halted_reg     <= halted_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // result payload, no reset needed
    always_ff @(posedge aclk) begin
        if (out_load) begin
            kind_reg  <= out_kind;
            addr_reg  <= out_addr;
            data_reg  <= out_data;
            rtype_reg <= out_type;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = kind_reg;
    assign m_tdata  = {rtype_reg, data_reg, addr_reg};

    // an error stops the parser until reset
    a_halt_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |=> halted_reg)
        else $error("halted flag cleared without reset");

    // a format error on the output always comes with the halt flag set
    a_format_halts: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && kind_reg == KIND_FORMAT) |-> halted_reg)
        else $error("format error reported while still running");

    // in the data phase at least one data byte is still owed
    a_data_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_DATA) |-> (bytes_left_reg != 8'd0))
        else $error("data phase with no bytes left");

    // once halted, no new result gets loaded
    a_halt_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        halted_reg |-> !out_load)
        else $error("result produced while halted");

endmodule
